### rtl/line_plane_intersection_unit_defines.svh
// Assertion macros shared by the line-plane intersection checker.
// No dependencies.
`ifndef LINE_PLANE_INTERSECTION_UNIT_DEFINES_SVH
`define LINE_PLANE_INTERSECTION_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LPI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lpi_pkg.sv
// Types and constants for the line-plane intersection pipeline.
// No dependencies.
package lpi_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int THR_W      = 62;
  localparam int DIV_BITS   = 32;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Data carried alongside the divider.
  typedef struct packed {
    logic   hit;
    logic   ovf;
    logic   neg;
    coord_t px;
    coord_t py;
    coord_t pz;
    coord_t vx;
    coord_t vy;
    coord_t vz;
  } lpi_side_t;
endpackage

### rtl/lpi_div.sv
// Pipelined restoring divider: DIV_BITS quotient bits, DIV_STEPS per stage.
// Depends on lpi_pkg.
module lpi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [63:0]        den_i,
  input  logic [63:0]        rem_i,
  input  logic [lpi_pkg::DIV_BITS-1:0] low_i,
  input  lpi_pkg::lpi_side_t side_i,
  output logic               valid_o,
  output logic [lpi_pkg::DIV_BITS-1:0] quo_o,
  output lpi_pkg::lpi_side_t side_o
);
  import lpi_pkg::*;

  logic                valid_q [DIV_STAGES+1];
  logic [63:0]         den_q   [DIV_STAGES+1];
  logic [63:0]         rem_q   [DIV_STAGES+1];
  logic [DIV_BITS-1:0] low_q   [DIV_STAGES+1];
  logic [DIV_BITS-1:0] quo_q   [DIV_STAGES+1];
  lpi_side_t           side_q  [DIV_STAGES+1];

  assign valid_q[0] = valid_i;
  assign den_q[0]   = den_i;
  assign rem_q[0]   = rem_i;
  assign low_q[0]   = low_i;
  assign quo_q[0]   = '0;
  assign side_q[0]  = side_i;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [63:0]         rem_d;
    logic [DIV_BITS-1:0] low_d;
    logic [DIV_BITS-1:0] quo_d;

    always_comb begin
      logic [64:0] trial;
      rem_d = rem_q[g];
      low_d = low_q[g];
      quo_d = quo_q[g];
      for (int s = 0; s < DIV_STEPS; s++) begin
        trial = {rem_d, low_d[DIV_BITS-1]};
        low_d = {low_d[DIV_BITS-2:0], 1'b0};
        if (trial >= {1'b0, den_q[g]}) begin
          rem_d = 64'(trial - {1'b0, den_q[g]});
          quo_d = {quo_d[DIV_BITS-2:0], 1'b1};
        end else begin
          rem_d = trial[63:0];
          quo_d = {quo_d[DIV_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[g+1] <= valid_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[g+1]  <= den_q[g];
        rem_q[g+1]  <= rem_d;
        low_q[g+1]  <= low_d;
        quo_q[g+1]  <= quo_d;
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign valid_o = valid_q[DIV_STAGES];
  assign quo_o   = quo_q[DIV_STAGES];
  assign side_o  = side_q[DIV_STAGES];
endmodule

### rtl/line_plane_intersection_unit.sv
// Line-plane intersection: 4 front stages, 16 divider stages at 2 quotient
// bits each, and 3 back stages; one transaction per cycle.
// The whole pipeline advances together; it stalls only when the output
// register holds a result not yet taken. rst_ni clears valid bits and the
// threshold register (threshold 0 after reset).
// Depends on lpi_pkg and lpi_div.
module line_plane_intersection_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lpi_pkg::THR_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lpi_pkg::coord_t             point_x_i,
  input  lpi_pkg::coord_t             point_y_i,
  input  lpi_pkg::coord_t             point_z_i,
  input  lpi_pkg::coord_t             dir_x_i,
  input  lpi_pkg::coord_t             dir_y_i,
  input  lpi_pkg::coord_t             dir_z_i,
  input  lpi_pkg::coord_t             plane_nx_i,
  input  lpi_pkg::coord_t             plane_ny_i,
  input  lpi_pkg::coord_t             plane_nz_i,
  input  lpi_pkg::coord_t             plane_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lpi_pkg::coord_t             hit_x_o,
  output lpi_pkg::coord_t             hit_y_o,
  output lpi_pkg::coord_t             hit_z_o,
  output logic                        hit_o,
  output logic                        saturated_o
);
  import lpi_pkg::*;

  localparam int DIV_W = PROD_W + FRAC_BITS;
  localparam int CMP_W = PROD_W + DIV_BITS;

  logic adv;
  logic [THR_W-1:0] thr_q;

  // stage valids
  logic s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q;

  coord_t p_in [3];
  coord_t v_in [3];
  coord_t n_in [3];

  // stage 1
  logic signed [PROD_W-1:0] nv_q [3];
  logic signed [PROD_W-1:0] np_q [3];
  coord_t w_q;
  coord_t p1_q [3];
  coord_t v1_q [3];
  // stage 2
  logic signed [SUM_W-1:0] den_q, num_q;
  coord_t p2_q [3];
  coord_t v2_q [3];
  // stage 3
  logic [63:0] den_mag_q, num_mag_q;
  logic neg3_q, hit3_q;
  coord_t p3_q [3];
  coord_t v3_q [3];
  // stage 4
  logic [63:0] den4_q, rem4_q;
  logic [DIV_BITS-1:0] low4_q;
  lpi_side_t side4_q;
  // divider out
  logic dv_valid;
  logic [DIV_BITS-1:0] dv_quo;
  lpi_side_t dv_side;
  // stage 5
  coord_t t_q;
  logic sat5_q;
  lpi_side_t side5_q;
  // stage 6
  logic signed [PROD_W-1:0] vt_q [3];
  logic sat6_q;
  lpi_side_t side6_q;
  // stage 7 / output
  coord_t hx_q, hy_q, hz_q;
  logic hit_q, sat_q;

  assign adv        = !s7_q || out_ready_i;
  assign in_ready_o = adv;

  assign p_in[0] = point_x_i;  assign p_in[1] = point_y_i;  assign p_in[2] = point_z_i;
  assign v_in[0] = dir_x_i;    assign v_in[1] = dir_y_i;    assign v_in[2] = dir_z_i;
  assign n_in[0] = plane_nx_i; assign n_in[1] = plane_ny_i; assign n_in[2] = plane_nz_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0; s2_q <= 1'b0; s3_q <= 1'b0; s4_q <= 1'b0;
      s5_q <= 1'b0; s6_q <= 1'b0; s7_q <= 1'b0;
    end else if (adv) begin
      s1_q <= in_valid_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;
      s5_q <= dv_valid;
      s6_q <= s5_q;
      s7_q <= s6_q;
    end
  end

  // Stages 1-3: dot products, sums, magnitudes, result sign and hit test.
  logic [SUM_W-1:0] den_abs, num_abs;
  assign den_abs = den_q[SUM_W-1] ? SUM_W'(-den_q) : den_q;
  assign num_abs = num_q[SUM_W-1] ? SUM_W'(-num_q) : num_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nv_q[i] <= n_in[i] * v_in[i];
        np_q[i] <= n_in[i] * p_in[i];
        p1_q[i] <= p_in[i];
        v1_q[i] <= v_in[i];
        p2_q[i] <= p1_q[i];
        v2_q[i] <= v1_q[i];
        p3_q[i] <= p2_q[i];
        v3_q[i] <= v2_q[i];
      end
      w_q <= plane_offset_i;
      den_q <= SUM_W'(nv_q[0]) + SUM_W'(nv_q[1]) + SUM_W'(nv_q[2]);
      num_q <= SUM_W'(np_q[0]) + SUM_W'(np_q[1]) + SUM_W'(np_q[2])
             + (SUM_W'(w_q) <<< FRAC_BITS);
      den_mag_q <= den_abs[63:0];
      num_mag_q <= num_abs[63:0];
      neg3_q    <= den_q[SUM_W-1] ^ num_q[SUM_W-1];
      hit3_q    <= den_abs[63:0] > 64'(thr_q);
    end
  end

  // Stage 4: overflow test and divider setup. Quotient fits DIV_BITS when
  // the scaled numerator is below den << DIV_BITS.
  logic [DIV_W-1:0] dvd;
  assign dvd = {num_mag_q, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den4_q      <= den_mag_q;
      rem4_q      <= 64'(dvd >> DIV_BITS);
      low4_q      <= dvd[DIV_BITS-1:0];
      side4_q.hit <= hit3_q;
      side4_q.ovf <= CMP_W'(dvd) >= {den_mag_q, {DIV_BITS{1'b0}}};
      side4_q.neg <= neg3_q;
      side4_q.px  <= p3_q[0];
      side4_q.py  <= p3_q[1];
      side4_q.pz  <= p3_q[2];
      side4_q.vx  <= v3_q[0];
      side4_q.vy  <= v3_q[1];
      side4_q.vz  <= v3_q[2];
    end
  end

  lpi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_q),
    .den_i   (den4_q),
    .rem_i   (rem4_q),
    .low_i   (low4_q),
    .side_i  (side4_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // Stage 5: clamp t to the signed 32-bit range.
  coord_t t_d;
  logic   tsat_d;
  always_comb begin
    if (dv_side.neg) begin
      tsat_d = dv_side.ovf || (dv_quo > {1'b1, {(DIV_BITS-1){1'b0}}});
      t_d    = tsat_d ? {1'b1, {(COORD_W-1){1'b0}}} : COORD_W'(-dv_quo);
    end else begin
      tsat_d = dv_side.ovf || dv_quo[DIV_BITS-1];
      t_d    = tsat_d ? {1'b0, {(COORD_W-1){1'b1}}} : COORD_W'(dv_quo);
    end
  end

  coord_t v6 [3];
  assign v6[0] = side5_q.vx;
  assign v6[1] = side5_q.vy;
  assign v6[2] = side5_q.vz;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q     <= t_d;
      sat5_q  <= tsat_d;
      side5_q <= dv_side;
      for (int i = 0; i < 3; i++) begin
        vt_q[i] <= v6[i] * t_q;
      end
      sat6_q  <= sat5_q;
      side6_q <= side5_q;
    end
  end

  // Stage 7: truncate v*t toward zero, subtract from p, clamp.
  localparam int Q_W = PROD_W - FRAC_BITS + 2;
  coord_t p7 [3];
  coord_t q7 [3];
  logic   qsat [3];
  assign p7[0] = side6_q.px;
  assign p7[1] = side6_q.py;
  assign p7[2] = side6_q.pz;

  always_comb begin
    logic [PROD_W-1:0] pm;
    logic signed [Q_W-1:0] s, q;
    for (int i = 0; i < 3; i++) begin
      pm = vt_q[i][PROD_W-1] ? PROD_W'(-vt_q[i]) : vt_q[i];
      s  = Q_W'(pm >> FRAC_BITS);
      if (vt_q[i][PROD_W-1]) begin
        s = -s;
      end
      q = Q_W'(p7[i]) - s;
      if (q > (Q_W'(1) <<< (COORD_W-1)) - Q_W'(1)) begin
        q7[i] = {1'b0, {(COORD_W-1){1'b1}}};
        qsat[i] = 1'b1;
      end else if (q < -(Q_W'(1) <<< (COORD_W-1))) begin
        q7[i] = {1'b1, {(COORD_W-1){1'b0}}};
        qsat[i] = 1'b1;
      end else begin
        q7[i] = q[COORD_W-1:0];
        qsat[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (side6_q.hit) begin
        hx_q  <= q7[0];
        hy_q  <= q7[1];
        hz_q  <= q7[2];
        hit_q <= 1'b1;
        sat_q <= sat6_q || qsat[0] || qsat[1] || qsat[2];
      end else begin
        hx_q  <= '0;
        hy_q  <= '0;
        hz_q  <= '0;
        hit_q <= 1'b0;
        sat_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = s7_q;
  assign hit_x_o     = hx_q;
  assign hit_y_o     = hy_q;
  assign hit_z_o     = hz_q;
  assign hit_o       = hit_q;
  assign saturated_o = sat_q;
endmodule

### rtl/lpi_checker.sv
// Port-level checks for line_plane_intersection_unit, bound to the top.
// Depends on lpi_pkg and line_plane_intersection_unit_defines.svh.
`include "line_plane_intersection_unit_defines.svh"

module lpi_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input lpi_pkg::coord_t hit_x_o,
  input lpi_pkg::coord_t hit_y_o,
  input lpi_pkg::coord_t hit_z_o,
  input logic            hit_o,
  input logic            saturated_o
);
  import lpi_pkg::*;

  // A miss carries zero coordinates and no clamp flag.
  `LPI_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, out_valid_o && !hit_o, hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0 && !saturated_o, "miss with nonzero payload")
  // Input side blocks only while a result waits.
  `LPI_ASSERT_NOW(a_ready_link, clk_i, rst_ni, 1'b1, in_ready_o == (!out_valid_o || out_ready_i), "in_ready mismatch with output stall")
  // Stalled result holds.
  `LPI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(hit_x_o) && $stable(hit_y_o) && $stable(hit_z_o) && $stable(hit_o) && $stable(saturated_o), "stalled result changed")
endmodule

bind line_plane_intersection_unit lpi_checker u_lpi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hit_x_o     (hit_x_o),
  .hit_y_o     (hit_y_o),
  .hit_z_o     (hit_z_o),
  .hit_o       (hit_o),
  .saturated_o (saturated_o)
);
